// ===== src/atb_pkg.sv =====
// Shared constants for the alias table builder: field widths, status codes
// and default parameter values. No dependencies.
`default_nettype none
package atb_pkg;
	localparam int WEIGHT_W = 32;
	localparam int RATIO_W = 28;
	localparam int ALIAS_W = 12;
	localparam int INDEX_W = 12;
	localparam int SUM_W = 44;
	localparam int STATUS_W = 2;

	localparam int DEF_MAX_ENTRIES = 4096;
	localparam int DEF_FRACTION_BITS = 16;

	localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_ZERO_SUM = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
endpackage
`default_nettype wire

// ===== src/atb_req_if.sv =====
// Request channel of the alias table builder: loads and reads.
// Depends on atb_pkg for field widths.
`default_nettype none
interface atb_req_if;
	logic valid;
	logic ready;
	logic kind;
	logic [atb_pkg::WEIGHT_W-1:0] weight;
	logic [atb_pkg::INDEX_W-1:0] entry_index;
	logic last;

	modport source (output valid, kind, weight, entry_index, last, input ready);
	modport sink (input valid, kind, weight, entry_index, last, output ready);
endinterface
`default_nettype wire

// ===== src/atb_rsp_if.sv =====
// Response channel of the alias table builder: one item per read.
// Depends on atb_pkg for field widths.
`default_nettype none
interface atb_rsp_if;
	logic valid;
	logic ready;
	logic [atb_pkg::RATIO_W-1:0] ratio;
	logic [atb_pkg::ALIAS_W-1:0] alias_entry;
	logic [atb_pkg::SUM_W-1:0] integral;
	logic [atb_pkg::STATUS_W-1:0] status;

	modport source (output valid, ratio, alias_entry, integral, status, input ready);
	modport sink (input valid, ratio, alias_entry, integral, status, output ready);
endinterface
`default_nettype wire

// ===== src/atb_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module atb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== src/alias_table_builder.sv =====
// Alias table builder top level; uses atb_pkg, atb_req_if, atb_rsp_if, atb_ram.
// Loads are taken while idle. A read waits in ST_RD until the result register is
// free. A build finds each ratio with a 28-step serial divider, then pairs small
// and large entries (one port per memory, sequential reads). Reset clears
// counters, sum, ready flag and state; memories hold no reset value and every
// entry below the count is rewritten by each build.
`default_nettype none
module alias_table_builder #(
	parameter int MAX_ENTRIES = atb_pkg::DEF_MAX_ENTRIES,
	parameter int FRACTION_BITS = atb_pkg::DEF_FRACTION_BITS
) (
	input wire logic clk,
	input wire logic arst_n,
	atb_req_if.sink req,
	atb_rsp_if.source rsp
);
	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int RW = atb_pkg::RATIO_W;
	localparam int SW = atb_pkg::SUM_W;
	localparam int MW = atb_pkg::WEIGHT_W + CW;
	localparam int XW = (MW > SW) ? MW : SW;
	localparam int DIV_SHIFT = RW - FRACTION_BITS;
	localparam logic [RW-1:0] ONE = RW'(1) << FRACTION_BITS;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

	// sequencer states
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD = 4'd1;
	localparam logic [3:0] ST_B_RD = 4'd2;
	localparam logic [3:0] ST_B_MUL = 4'd3;
	localparam logic [3:0] ST_B_DIV0 = 4'd4;
	localparam logic [3:0] ST_B_DIV = 4'd5;
	localparam logic [3:0] ST_B_WR = 4'd6;
	localparam logic [3:0] ST_P_LO = 4'd7;
	localparam logic [3:0] ST_P_HI = 4'd8;
	localparam logic [3:0] ST_P_RLO = 4'd9;
	localparam logic [3:0] ST_P_RHI = 4'd10;
	localparam logic [3:0] ST_P_UPD = 4'd11;

	logic [3:0] state_q;
	logic [CW-1:0] count_q;
	logic [SW-1:0] sum_q;
	logic ready_q;

	// build counters: entry, small fill / pair cursor, large boundary
	logic [CW-1:0] i_q;
	logic [CW-1:0] s_q;
	logic [CW-1:0] large_q;

	// divider
	logic [MW-1:0] mult_s1;
	logic [SW-1:0] rem_q;
	logic [RW-1:0] low_q;
	logic [RW-1:0] quo_q;
	logic [4:0] step_q;

	// pairing
	logic [AW-1:0] lo_q;
	logic [AW-1:0] hi_q;
	logic [RW-1:0] rlo_q;

	// read item and result register
	logic [atb_pkg::INDEX_W-1:0] idx_q;
	logic out_valid_q;
	logic [RW-1:0] out_ratio_q;
	logic [atb_pkg::ALIAS_W-1:0] out_alias_q;
	logic [SW-1:0] out_sum_q;
	logic [atb_pkg::STATUS_W-1:0] out_status_q;

	// memory ports
	logic w_we, r_we, a_we, p_we;
	logic [AW-1:0] w_waddr, w_raddr, r_waddr, r_raddr, a_waddr, a_raddr, p_waddr, p_raddr;
	logic [atb_pkg::WEIGHT_W-1:0] w_wdata, w_rdata;
	logic [RW-1:0] r_wdata, r_rdata;
	logic [atb_pkg::ALIAS_W-1:0] a_wdata, a_rdata;
	logic [AW-1:0] p_wdata, p_rdata;

	atb_ram #(.WIDTH(atb_pkg::WEIGHT_W), .DEPTH(MAX_ENTRIES)) u_weight_ram (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.raddr(w_raddr), .rdata(w_rdata));
	atb_ram #(.WIDTH(RW), .DEPTH(MAX_ENTRIES)) u_ratio_ram (
		.clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
		.raddr(r_raddr), .rdata(r_rdata));
	atb_ram #(.WIDTH(atb_pkg::ALIAS_W), .DEPTH(MAX_ENTRIES)) u_alias_ram (
		.clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
		.raddr(a_raddr), .rdata(a_rdata));
	atb_ram #(.WIDTH(AW), .DEPTH(MAX_ENTRIES)) u_part_ram (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata));

	logic acc;
	logic load_acc;
	logic [CW-1:0] cnt_eff;
	logic [SW-1:0] sum_eff;
	logic [SW:0] sum_add;
	logic room;

	assign req.ready = (state_q == ST_IDLE);
	assign acc = req.valid && req.ready;
	assign load_acc = acc && (req.kind == atb_pkg::KIND_LOAD);

	// a load after a finished build opens a new set
	assign cnt_eff = ready_q ? '0 : count_q;
	assign sum_eff = ready_q ? '0 : sum_q;
	assign room = (cnt_eff < MAX_CNT);
	assign sum_add = {1'b0, sum_eff} + (SW + 1)'(req.weight);

	// divider step: bring down one numerator bit, compare and subtract
	logic [SW:0] div_t;
	logic div_ge;
	logic [XW-1:0] rem0_x;
	logic [XW-1:0] den_x;
	logic div_sat;
	assign div_t = {rem_q, low_q[RW-1]};
	assign div_ge = (div_t >= {1'b0, sum_q});
	assign rem0_x = XW'(mult_s1 >> DIV_SHIFT);
	assign den_x = XW'(sum_q);
	assign div_sat = (rem0_x >= den_x);

	// ratio classification after phase one
	logic is_small;
	logic [CW-1:0] s_after, large_after;
	assign is_small = (quo_q < ONE);
	assign s_after = is_small ? s_q + CW'(1) : s_q;
	assign large_after = is_small ? large_q : large_q - CW'(1);

	// pairing update: large ratio loses one minus small ratio
	logic [RW-1:0] diff;
	logic [RW-1:0] rhi_new;
	logic [CW-1:0] s_nx, large_nx;
	assign diff = ONE - rlo_q;
	assign rhi_new = (r_rdata >= diff) ? r_rdata - diff : '0;
	assign s_nx = s_q + CW'(1);
	assign large_nx = (rhi_new < ONE) ? large_q + CW'(1) : large_q;

	// read address for a read item
	logic [AW-1:0] idx_addr;
	assign idx_addr = AW'(idx_q);

	always_comb begin
		w_we = load_acc && room;
		w_waddr = cnt_eff[AW-1:0];
		w_wdata = req.weight;
		w_raddr = i_q[AW-1:0];

		r_we = 1'b0;
		r_waddr = i_q[AW-1:0];
		r_wdata = quo_q;
		a_we = 1'b0;
		a_waddr = i_q[AW-1:0];
		a_wdata = atb_pkg::ALIAS_W'(i_q);
		p_we = 1'b0;
		p_waddr = s_q[AW-1:0];
		p_wdata = i_q[AW-1:0];

		r_raddr = AW'(req.entry_index);
		a_raddr = AW'(req.entry_index);
		p_raddr = s_q[AW-1:0];

		case (state_q)
			ST_RD: begin
				r_raddr = idx_addr;
				a_raddr = idx_addr;
			end
			ST_B_WR: begin
				r_we = 1'b1;
				a_we = 1'b1;
				p_we = (sum_q != '0);
				p_waddr = is_small ? s_q[AW-1:0] : large_after[AW-1:0];
			end
			ST_P_HI: begin
				p_raddr = large_q[AW-1:0];
			end
			ST_P_RLO: begin
				r_raddr = lo_q;
			end
			ST_P_RHI: begin
				r_raddr = hi_q;
			end
			ST_P_UPD: begin
				r_we = 1'b1;
				r_waddr = hi_q;
				r_wdata = rhi_new;
				a_we = 1'b1;
				a_waddr = lo_q;
				a_wdata = atb_pkg::ALIAS_W'(hi_q);
			end
			default: begin
			end
		endcase
	end

	// result fields for a read
	logic rd_bad;
	assign rd_bad = !ready_q || (CW'(idx_q) >= count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			sum_q <= '0;
			ready_q <= 1'b0;
			i_q <= '0;
			s_q <= '0;
			large_q <= '0;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load a new result once the register is free, drop it once taken
			if (state_q == ST_RD && (!out_valid_q || rsp.ready)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (load_acc) begin
						ready_q <= 1'b0;
						count_q <= room ? cnt_eff + CW'(1) : cnt_eff;
						if (room) begin
							sum_q <= sum_add[SW] ? atb_pkg::SUM_MAX : sum_add[SW-1:0];
						end else begin
							sum_q <= sum_eff;
						end
						if (req.last) begin
							i_q <= '0;
							s_q <= '0;
							large_q <= room ? cnt_eff + CW'(1) : cnt_eff;
							state_q <= ST_B_RD;
						end
					end else if (acc) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					// hold until the result register is free
					if (!out_valid_q || rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				ST_B_RD: begin
					state_q <= ST_B_MUL;
				end
				ST_B_MUL: begin
					state_q <= (sum_q == '0) ? ST_B_WR : ST_B_DIV0;
				end
				ST_B_DIV0: begin
					step_q <= '0;
					state_q <= div_sat ? ST_B_WR : ST_B_DIV;
				end
				ST_B_DIV: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'(RW - 1)) begin
						state_q <= ST_B_WR;
					end
				end
				ST_B_WR: begin
					if (i_q + CW'(1) == count_q) begin
						s_q <= '0;
						large_q <= large_after;
						if (sum_q != '0 && large_after != '0 && large_after < count_q) begin
							state_q <= ST_P_LO;
						end else begin
							ready_q <= 1'b1;
							state_q <= ST_IDLE;
						end
					end else begin
						i_q <= i_q + CW'(1);
						s_q <= s_after;
						large_q <= large_after;
						state_q <= ST_B_RD;
					end
				end
				ST_P_LO: begin
					state_q <= ST_P_HI;
				end
				ST_P_HI: begin
					state_q <= ST_P_RLO;
				end
				ST_P_RLO: begin
					state_q <= ST_P_RHI;
				end
				ST_P_RHI: begin
					state_q <= ST_P_UPD;
				end
				ST_P_UPD: begin
					s_q <= s_nx;
					large_q <= large_nx;
					if (s_nx < large_nx && large_nx < count_q) begin
						state_q <= ST_P_LO;
					end else begin
						ready_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (acc) begin
			idx_q <= req.entry_index;
		end
		if (state_q == ST_B_MUL) begin
			mult_s1 <= MW'(w_rdata) * MW'(count_q);
			quo_q <= '0;
		end
		if (state_q == ST_B_DIV0) begin
			rem_q <= rem0_x[SW-1:0];
			low_q <= RW'(mult_s1 << FRACTION_BITS);
			quo_q <= div_sat ? atb_pkg::RATIO_MAX : '0;
		end
		if (state_q == ST_B_DIV) begin
			rem_q <= div_ge ? SW'(div_t - {1'b0, sum_q}) : div_t[SW-1:0];
			low_q <= {low_q[RW-2:0], 1'b0};
			quo_q <= {quo_q[RW-2:0], div_ge};
		end
		if (state_q == ST_P_HI) begin
			lo_q <= p_rdata;
		end
		if (state_q == ST_P_RLO) begin
			hi_q <= p_rdata;
		end
		if (state_q == ST_P_RHI) begin
			rlo_q <= r_rdata;
		end
		if (state_q == ST_RD && (!out_valid_q || rsp.ready)) begin
			if (rd_bad) begin
				out_ratio_q <= '0;
				out_alias_q <= '0;
				out_sum_q <= ready_q ? sum_q : '0;
				out_status_q <= atb_pkg::STATUS_RANGE;
			end else begin
				out_ratio_q <= r_rdata;
				out_alias_q <= a_rdata;
				out_sum_q <= sum_q;
				out_status_q <= (sum_q == '0) ? atb_pkg::STATUS_ZERO_SUM : atb_pkg::STATUS_OK;
			end
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.ratio = out_ratio_q;
	assign rsp.alias_entry = out_alias_q;
	assign rsp.integral = out_sum_q;
	assign rsp.status = out_status_q;

`ifndef SYNTH
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("entry count above capacity");
	a_build_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_B_RD) |-> (count_q != '0) && (i_q < count_q))
		else $error("build walks past the loaded count");
	a_pair_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_P_LO) |-> (s_q < large_q) && (large_q < count_q))
		else $error("pairing cursor out of bounds");
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> rsp.valid
			&& $stable({rsp.ratio, rsp.alias_entry, rsp.integral, rsp.status}))
		else $error("stalled result changed or dropped");
`endif
endmodule
`default_nettype wire
